// ===== rtl/rmst_pkg.sv =====
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared field widths, operation codes and the result bundle of the range
// maximum segment tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

  // Field widths
  localparam int OPC_W = 2;
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;

  // Leaf count after reset
  localparam logic [CNT_W-1:0] LEAF_COUNT_RST = 11'd1024;

  // Operation codes
  localparam logic [OPC_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OPC_W-1:0] OP_BUILD  = 2'd1;
  localparam logic [OPC_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OPC_W-1:0] OP_UPDATE = 2'd3;

  // Query result from the sequencer to the output ports
  typedef struct packed {
    logic                    valid;
    logic                    empty;
    logic signed [VAL_W-1:0] max;
  } rmst_result_t;

endpackage

// ===== rtl/rmst_node_ram.sv =====
// ----------------------------------------------------------------------------
// rmst_node_ram
// Node store: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module rmst_node_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr0,
  input  logic [AW-1:0] rd_addr1,
  output logic [DW-1:0] rd_data0_r,
  output logic [DW-1:0] rd_data1_r
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports, read data registered
  always_ff @(posedge clk) begin
    rd_data0_r <= mem[rd_addr0];
    rd_data1_r <= mem[rd_addr1];
  end

endmodule

// ===== rtl/rmst_seq.sv =====
// ----------------------------------------------------------------------------
// rmst_seq
// Operation sequencer: decodes a transaction, walks the node store with
// read-modify-write steps and forms the query result.
// ----------------------------------------------------------------------------
module rmst_seq #(
  parameter int NW = 11
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [NW-1:0]                     leaves,
  input  logic                              start,
  output logic                              busy,
  input  logic [rmst_pkg::OPC_W-1:0]        in_opcode,
  input  logic [rmst_pkg::IDX_W-1:0]        in_left_index,
  input  logic [rmst_pkg::IDX_W-1:0]        in_right_index,
  input  logic signed [rmst_pkg::VAL_W-1:0] in_leaf_value,
  output logic                              wr_en,
  output logic [NW-1:0]                     wr_addr,
  output logic signed [rmst_pkg::VAL_W-1:0] wr_data,
  output logic [NW-1:0]                     rd_addr0,
  output logic [NW-1:0]                     rd_addr1,
  input  logic signed [rmst_pkg::VAL_W-1:0] rd_data0,
  input  logic signed [rmst_pkg::VAL_W-1:0] rd_data1,
  output rmst_pkg::rmst_result_t            result_r
);

  import rmst_pkg::*;

  localparam int IW = (NW > IDX_W) ? NW : IDX_W;
  localparam int XW = IW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BRD  = 3'd1;
  localparam logic [2:0] S_BWR  = 3'd2;
  localparam logic [2:0] S_URD  = 3'd3;
  localparam logic [2:0] S_UWR  = 3'd4;
  localparam logic [2:0] S_QRD  = 3'd5;
  localparam logic [2:0] S_QCMB = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [NW:0]             k_r, k_nxt;
  logic [NW:0]             r_r, r_nxt;
  logic signed [VAL_W-1:0] cur_r, cur_nxt;
  logic                    found_r, found_nxt;
  rmst_result_t            result_nxt;

  logic                    accept;
  logic [XW-1:0]           n_x, li_x, ri_x, ri_sat, leaf_x, r0_x;
  logic                    li_ok, q_empty;
  logic signed [VAL_W-1:0] pair_max, up_max;
  logic [NW:0]             l_t, r_t;
  logic signed [VAL_W-1:0] b_t;
  logic                    f_t;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Decode indices against the effective leaf count
  always_comb begin
    n_x     = XW'(leaves);
    li_x    = XW'(in_left_index);
    ri_x    = XW'(in_right_index);
    ri_sat  = (ri_x > n_x - XW'(1)) ? (n_x - XW'(1)) : ri_x;
    li_ok   = (li_x < n_x);
    q_empty = (li_x > ri_sat);
    leaf_x  = n_x + li_x;
    r0_x    = n_x + ri_sat;
  end

  // Pairwise maxima for build and update
  assign pair_max = (rd_data0 > rd_data1) ? rd_data0 : rd_data1;
  assign up_max   = (rd_data0 > cur_r) ? rd_data0 : cur_r;

  // Fold one level of the query walk
  always_comb begin
    l_t = k_r;
    r_t = r_r;
    b_t = cur_r;
    f_t = found_r;
    if (k_r[0]) begin
      if (!f_t || rd_data0 > b_t) begin
        b_t = rd_data0;
      end
      f_t = 1'b1;
      l_t = k_r + (NW+1)'(1);
    end
    if (!r_r[0]) begin
      if (!f_t || rd_data1 > b_t) begin
        b_t = rd_data1;
      end
      f_t = 1'b1;
      r_t = r_r - (NW+1)'(1);
    end
    l_t = l_t >> 1;
    r_t = r_t >> 1;
  end

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    k_nxt            = k_r;
    r_nxt            = r_r;
    cur_nxt          = cur_r;
    found_nxt        = found_r;
    result_nxt       = result_r;
    result_nxt.valid = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = '0;
    wr_data          = in_leaf_value;
    rd_addr0         = '0;
    rd_addr1         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            OP_LOAD: begin
              if (li_ok) begin
                wr_en   = 1'b1;
                wr_addr = leaf_x[NW-1:0];
              end
            end
            OP_BUILD: begin
              k_nxt     = (NW+1)'(leaves) - (NW+1)'(1);
              state_nxt = S_BRD;
            end
            OP_UPDATE: begin
              if (li_ok) begin
                wr_en     = 1'b1;
                wr_addr   = leaf_x[NW-1:0];
                cur_nxt   = in_leaf_value;
                k_nxt     = leaf_x[NW:0];
                state_nxt = S_URD;
              end
            end
            OP_QUERY: begin
              if (q_empty) begin
                result_nxt.valid = 1'b1;
                result_nxt.empty = 1'b1;
                result_nxt.max   = '0;
              end else begin
                k_nxt     = leaf_x[NW:0];
                r_nxt     = r0_x[NW:0];
                found_nxt = 1'b0;
                cur_nxt   = '0;
                state_nxt = S_QRD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      // Build: read both children, then write the parent
      S_BRD: begin
        if (k_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          rd_addr0  = {k_r[NW-2:0], 1'b0};
          rd_addr1  = {k_r[NW-2:0], 1'b1};
          state_nxt = S_BWR;
        end
      end
      S_BWR: begin
        wr_en     = 1'b1;
        wr_addr   = k_r[NW-1:0];
        wr_data   = pair_max;
        k_nxt     = k_r - (NW+1)'(1);
        state_nxt = S_BRD;
      end
      // Update: read the sibling, then write the parent
      S_URD: begin
        if (k_r == (NW+1)'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          rd_addr0  = k_r[NW-1:0] ^ NW'(1);
          state_nxt = S_UWR;
        end
      end
      S_UWR: begin
        wr_en     = 1'b1;
        wr_addr   = k_r[NW:1];
        wr_data   = up_max;
        cur_nxt   = up_max;
        k_nxt     = k_r >> 1;
        state_nxt = S_URD;
      end
      // Query: read both bounds, then fold them in and climb
      S_QRD: begin
        if (k_r > r_r) begin
          result_nxt.valid = 1'b1;
          result_nxt.empty = !found_r;
          result_nxt.max   = found_r ? cur_r : '0;
          state_nxt        = S_IDLE;
        end else begin
          rd_addr0  = k_r[NW-1:0];
          rd_addr1  = r_r[NW-1:0];
          state_nxt = S_QCMB;
        end
      end
      S_QCMB: begin
        k_nxt     = l_t;
        r_nxt     = r_t;
        cur_nxt   = b_t;
        found_nxt = f_t;
        state_nxt = S_QRD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      result_r <= '0;
    end else begin
      state_r  <= state_nxt;
      result_r <= result_nxt;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    r_r     <= r_nxt;
    cur_r   <= cur_nxt;
    found_r <= found_nxt;
  end

endmodule

// ===== rtl/range_max_segment_tree.sv =====
// ----------------------------------------------------------------------------
// range_max_segment_tree
// Bottom-up segment tree of signed range maxima held in a 2N-entry node RAM.
// Supports leaf load, full build, inclusive range max query, point update.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       start / busy         in_opcode, in_left_index, in_right_index,
//                                 in_leaf_value
//   out      out_valid (strobe)   out_range_max, out_range_empty
//   cfg      cfg_valid/cfg_ready  cfg_data (leaf count)
//
// Build and update take each node as a read step, then a write step on the
// single RAM write port; a query reads both bounds of a level, then folds
// them in. A load and an empty query are handled from the idle state.
// Reset leaves the node RAM unwritten; the leaf count returns to 1024.
// A query result appears for exactly one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module range_max_segment_tree #(
  parameter int MAX_LEAVES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [rmst_pkg::OPC_W-1:0]        in_opcode,
  input  logic [rmst_pkg::IDX_W-1:0]        in_left_index,
  input  logic [rmst_pkg::IDX_W-1:0]        in_right_index,
  input  logic signed [rmst_pkg::VAL_W-1:0] in_leaf_value,
  output logic                              out_valid,
  output logic signed [rmst_pkg::VAL_W-1:0] out_range_max,
  output logic                              out_range_empty,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rmst_pkg::CNT_W-1:0]        cfg_data
);

  import rmst_pkg::*;

  localparam int DEPTH = 2 * MAX_LEAVES;
  localparam int NW    = $clog2(DEPTH);

  logic [CNT_W-1:0]        leaf_count_r;
  logic [31:0]             lc_ext;
  logic [NW-1:0]           leaves;
  logic                    wr_en;
  logic [NW-1:0]           wr_addr, rd_addr0, rd_addr1;
  logic signed [VAL_W-1:0] wr_data, rd_data0, rd_data1;
  rmst_result_t            result;

  // Leaf count register
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_count_r <= LEAF_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      leaf_count_r <= cfg_data;
    end
  end

  // Clamp the leaf count to the supported range
  always_comb begin
    lc_ext = 32'(leaf_count_r);
    if (lc_ext == 32'd0) begin
      leaves = NW'(1);
    end else if (lc_ext > 32'(MAX_LEAVES)) begin
      leaves = NW'(MAX_LEAVES);
    end else begin
      leaves = lc_ext[NW-1:0];
    end
  end

  rmst_seq #(
    .NW (NW)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .leaves         (leaves),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_left_index  (in_left_index),
    .in_right_index (in_right_index),
    .in_leaf_value  (in_leaf_value),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_addr0       (rd_addr0),
    .rd_addr1       (rd_addr1),
    .rd_data0       (rd_data0),
    .rd_data1       (rd_data1),
    .result_r       (result)
  );

  rmst_node_ram #(
    .DEPTH (DEPTH),
    .AW    (NW),
    .DW    (VAL_W)
  ) u_ram (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr0   (rd_addr0),
    .rd_addr1   (rd_addr1),
    .rd_data0_r (rd_data0),
    .rd_data1_r (rd_data1)
  );

  // Drive the result transaction
  assign out_valid       = result.valid;
  assign out_range_max   = result.max;
  assign out_range_empty = result.empty;

endmodule

// ===== sim/range_max_segment_tree_tb.sv =====
// ----------------------------------------------------------------------------
// range_max_segment_tree_tb
// Drives loads, builds, range maximum queries and point updates into the
// segment tree. It tracks the node store and leaf count in a scoreboard,
// and checks every query answer in order against the tracked tree. It also
// covers several leaf count settings, stale trees and out-of-range indices.
// ----------------------------------------------------------------------------
module range_max_segment_tree_tb;
  import rmst_pkg::*;

  localparam int TREE_LEAVES = 1024;
  localparam int NODE_COUNT  = 2 * TREE_LEAVES;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct {
    logic signed [VAL_W-1:0] peak;
    logic                    empty;
  } range_answer_t;

  // Tracks the node store and holds the answers still owed by the block
  class range_max_scoreboard;
    logic signed [VAL_W-1:0] node_val [NODE_COUNT];
    bit                      node_known [NODE_COUNT];
    int unsigned             leaf_reg;
    range_answer_t           answers_due [$];
    int unsigned             fault_count;

    function new();
      leaf_reg    = LEAF_COUNT_RST;
      fault_count = 0;
      foreach (node_known[k]) begin
        node_known[k] = 1'b0;
        node_val[k]   = '0;
      end
    endfunction

    function void set_leaf_count(logic [CNT_W-1:0] count);
      leaf_reg = count;
    endfunction

    // Clamp the register into the supported leaf range
    function int unsigned leaves_in_use();
      if (leaf_reg < 1) return 1;
      if (leaf_reg > TREE_LEAVES) return TREE_LEAVES;
      return leaf_reg;
    endfunction

    function int unsigned pending();
      return answers_due.size();
    endfunction

    // Recompute one internal node from its two children
    function void fold_node(int unsigned k);
      node_val[k]   = (node_val[2*k] > node_val[2*k+1]) ? node_val[2*k] : node_val[2*k+1];
      node_known[k] = 1'b1;
    endfunction

    // Walk both bounds upward; also flag whether every node read was written
    function void walk_query(int unsigned li, int unsigned ri,
                             output range_answer_t ans, output bit all_known);
      int unsigned n, hi, l, r;
      int unsigned hits [$];
      n         = leaves_in_use();
      hi        = (ri > n - 1) ? n - 1 : ri;
      all_known = 1'b1;
      ans.peak  = '0;
      ans.empty = 1'b1;
      if (li > hi) return;
      l = li + n;
      r = hi + n;
      while (l <= r) begin
        if (l % 2 == 1) begin
          hits = {hits, l};
          l++;
        end
        if (r % 2 == 0) begin
          hits = {hits, r};
          r--;
        end
        l >>= 1;
        r >>= 1;
      end
      foreach (hits[i]) begin
        if (!node_known[hits[i]]) all_known = 1'b0;
        if (i == 0 || node_val[hits[i]] > ans.peak) ans.peak = node_val[hits[i]];
      end
      ans.empty = (hits.size() == 0);
    endfunction

    // True when the operation reads only nodes that have been written
    function bit op_safe(logic [OPC_W-1:0] op, int unsigned li, int unsigned ri);
      int unsigned   n, k;
      range_answer_t ans;
      bit            all_known;
      n         = leaves_in_use();
      all_known = 1'b1;
      case (op)
        OP_BUILD: begin
          if (n > 1) begin
            for (k = n; k < 2 * n; k++) begin
              if (!node_known[k]) all_known = 1'b0;
            end
          end
        end
        OP_UPDATE: begin
          if (li < n) begin
            k = n + li;
            while (k > 1) begin
              if (!node_known[k ^ 1]) all_known = 1'b0;
              k >>= 1;
            end
          end
        end
        OP_QUERY: begin
          walk_query(li, ri, ans, all_known);
        end
        default: ;
      endcase
      return all_known;
    endfunction

    // Advance the tracked tree by one accepted transaction
    function void apply_op(logic [OPC_W-1:0] op, int unsigned li, int unsigned ri,
                           logic signed [VAL_W-1:0] val);
      int unsigned   n, k;
      range_answer_t ans;
      bit            all_known;
      n = leaves_in_use();
      case (op)
        OP_LOAD: begin
          if (li < n) begin
            node_val[n + li]   = val;
            node_known[n + li] = 1'b1;
          end
        end
        OP_BUILD: begin
          for (int j = n - 1; j >= 1; j--) fold_node(j);
        end
        OP_UPDATE: begin
          if (li < n) begin
            k             = n + li;
            node_val[k]   = val;
            node_known[k] = 1'b1;
            while (k > 1) begin
              k >>= 1;
              fold_node(k);
            end
          end
        end
        default: begin
          walk_query(li, ri, ans, all_known);
          answers_due = {answers_due, ans};
        end
      endcase
    endfunction

    task report_mismatch(string what);
      fault_count++;
      if (fault_count <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compare a strobed answer with the oldest one owed
    task check_answer(logic signed [VAL_W-1:0] peak, logic empty);
      range_answer_t due;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("answer with none owed: max %0d empty %0b", peak, empty));
        return;
      end
      due = answers_due.pop_front();
      if (peak !== due.peak)
        report_mismatch($sformatf("range_max %0d, wanted %0d", peak, due.peak));
      if (empty !== due.empty)
        report_mismatch($sformatf("range_empty %0b, wanted %0b", empty, due.empty));
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [OPC_W-1:0]        in_opcode;
  logic [IDX_W-1:0]        in_left_index;
  logic [IDX_W-1:0]        in_right_index;
  logic signed [VAL_W-1:0] in_leaf_value;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_range_max;
  logic                    out_range_empty;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CNT_W-1:0]        cfg_data;

  range_max_scoreboard sb;
  int unsigned         burst_left;

  range_max_segment_tree #(
    .MAX_LEAVES(TREE_LEAVES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_left_index   (in_left_index),
    .in_right_index  (in_right_index),
    .in_leaf_value   (in_leaf_value),
    .out_valid       (out_valid),
    .out_range_max   (out_range_max),
    .out_range_empty (out_range_empty),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check every strobed answer
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_answer(out_range_max, out_range_empty);
  end

  // Bias towards the signed extremes and small values near zero
  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // Issue one transaction in bursts with random gaps; skip reads of unwritten nodes
  task automatic send_op(input logic [OPC_W-1:0] op, input int unsigned li,
                         input int unsigned ri, input logic signed [VAL_W-1:0] val);
    int unsigned gap;
    if (!sb.op_safe(op, li, ri)) return;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start          <= 1'b1;
    in_opcode      <= op;
    in_left_index  <= IDX_W'(li);
    in_right_index <= IDX_W'(ri);
    in_leaf_value  <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.apply_op(op, li, ri, val);
  endtask

  // Hold off until every answer is in, then idle for a margin that scales with the leaf count
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * sb.leaves_in_use() + 64) @(posedge clk);
  endtask

  task automatic write_leaf_count(input logic [CNT_W-1:0] count);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_leaf_count(count);
    burst_left = 0;
  endtask

  // Load every leaf in use
  task automatic fill_leaves();
    int unsigned n;
    n = sb.leaves_in_use();
    for (int unsigned i = 0; i < n; i++) send_op(OP_LOAD, i, $urandom_range(0, 1023), rand_value());
  endtask

  // Random mix weighted towards queries and updates on a built tree
  task automatic random_ops(input int unsigned count);
    int unsigned      n, pick, li, ri;
    logic [OPC_W-1:0] op;
    repeat (count) begin
      n    = sb.leaves_in_use();
      pick = $urandom_range(0, 99);
      if (pick < 45) op = OP_QUERY;
      else if (pick < 70) op = OP_UPDATE;
      else if (pick < 92) op = OP_LOAD;
      else op = OP_BUILD;
      li = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, n - 1);
      case ($urandom_range(0, 9))
        0: ri = $urandom_range(0, 1023);
        1: ri = (li == 0) ? 0 : $urandom_range(0, li - 1);
        default: ri = li + $urandom_range(0, n - 1);
      endcase
      if (ri > 1023) ri = 1023;
      // now and then hold the sender until every answer is back
      if ($urandom_range(0, 63) == 0) begin
        start <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      send_op(op, li, ri, rand_value());
    end
  endtask

  initial begin
    int unsigned phase_counts [8];
    phase_counts = '{1, 2, 3, 5, 8, 13, 64, 1024};
    sb         = new();
    burst_left = 0;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_opcode      <= OP_LOAD;
    in_left_index  <= '0;
    in_right_index <= '0;
    in_leaf_value  <= '0;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // The reset leaf count places the last leaf at the top of the store
    send_op(OP_LOAD, 1023, 0, 32'sd42);
    send_op(OP_QUERY, 1023, 1023, '0);
    send_op(OP_QUERY, 5, 2, '0);

    // Full tree at a mid-size leaf count, then the boundary cases
    write_leaf_count(11'd160);
    fill_leaves();
    send_op(OP_BUILD, 0, 0, '0);
    send_op(OP_QUERY, 0, 1023, '0);
    send_op(OP_QUERY, 0, 0, '0);
    send_op(OP_QUERY, 159, 159, '0);
    send_op(OP_QUERY, 700, 2, '0);
    send_op(OP_QUERY, 3, 1023, '0);
    send_op(OP_UPDATE, 0, 0, VAL_MAX);
    send_op(OP_QUERY, 0, 1, '0);
    send_op(OP_UPDATE, 159, 0, VAL_MIN);
    send_op(OP_QUERY, 158, 159, '0);
    // load without rebuilding: the ancestors stay stale
    send_op(OP_LOAD, 9, 0, -32'sd1);
    send_op(OP_QUERY, 8, 9, '0);
    send_op(OP_QUERY, 9, 9, '0);
    send_op(OP_BUILD, 0, 0, '0);
    send_op(OP_QUERY, 8, 9, '0);
    random_ops(100);

    // A count above the maximum acts as the maximum; the full walk hits the root
    write_leaf_count(11'd2047);
    send_op(OP_QUERY, 0, 1023, '0);
    send_op(OP_LOAD, 700, 0, 32'sd3);
    send_op(OP_QUERY, 700, 700, '0);
    random_ops(40);

    // A count of zero acts as one leaf; out-of-range loads and updates drop
    write_leaf_count(11'd0);
    send_op(OP_QUERY, 0, 0, '0);
    send_op(OP_QUERY, 0, 1023, '0);
    send_op(OP_LOAD, 5, 0, 32'sd77);
    send_op(OP_UPDATE, 3, 0, 32'sd88);
    send_op(OP_LOAD, 0, 0, VAL_MIN);
    send_op(OP_QUERY, 0, 0, '0);
    send_op(OP_UPDATE, 0, 0, -32'sd5);
    send_op(OP_BUILD, 0, 0, '0);
    send_op(OP_QUERY, 1, 0, '0);
    random_ops(40);

    // Step through further counts; probe the old tree before refilling it
    foreach (phase_counts[p]) begin
      write_leaf_count(CNT_W'(phase_counts[p]));
      random_ops(8);
      if (phase_counts[p] != TREE_LEAVES) begin
        fill_leaves();
        send_op(OP_BUILD, 0, 0, '0);
      end
      random_ops(20);
    end

    drain();
    if (sb.fault_count == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // End the run if the block hangs
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
